// File: rtl/tgd_pkg.sv
// tgd_pkg: types, result codes and sizing constants for the TGA stream decoder.
// No dependencies; used by every module under rtl/.
`default_nettype none

package tgd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_CMAP     = 3'd0;
   localparam logic [2:0] ERR_TYPE     = 3'd1;
   localparam logic [2:0] ERR_SIZE     = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_TRUNC    = 3'd4;

   // Header layout
   localparam int unsigned HDR_BYTES = 18;

   // Default depth of the event queue between parser and formatter
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] pixel_bgra;
      logic [31:0] start_index;
      logic [7:0]  run_length;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        top_origin;
      logic [2:0]  error_code;
      logic        image_done;
   } rsp_type;

   // Compact event from parser to formatter.
   // data: pixel (or grey byte in [7:0]) for runs, {height, width} for headers.
   typedef struct packed {
      logic [1:0]  kind;
      logic        gray;
      logic [31:0] data;
      logic [31:0] start;
      logic [7:0]  len;
      logic        top;
      logic [2:0]  code;
      logic        done;
   } evt_type;

endpackage

`default_nettype wire

// File: rtl/tgd_parser.sv
// tgd_parser: front end; takes file bytes, walks header / ID / packet / pixel phases.
// Emits at most one compact event per byte. Depends on tgd_pkg.
`default_nettype none

module tgd_parser (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire tgd_pkg::req_type req_item,
   output logic                 evt_push,
   output tgd_pkg::evt_type     evt
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_IDSKIP = 3'd2;
   localparam logic [2:0] PH_PACKET = 3'd3;
   localparam logic [2:0] PH_PIXEL  = 3'd4;

   localparam logic [4:0] POS_LAST = 5'(tgd_pkg::HDR_BYTES - 1);

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  hdr_pos_ff, hdr_pos_in;
   logic [7:0]  id_left_ff, id_left_in;
   logic        compressed_ff, compressed_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] done_cnt_ff, done_cnt_in;
   logic        repeat_ff, repeat_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic [23:0] assembly_ff, assembly_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;

   logic [7:0]  b;
   logic [2:0]  cur_phase;
   logic [4:0]  cur_pos;
   logic [2:0]  data_phase;
   logic        err;
   logic [2:0]  err_code;
   logic        complete;
   logic [7:0]  id_dec;
   logic [7:0]  run;
   logic [32:0] run_end;
   logic [23:0] asm_new;
   logic [7:0]  n;
   logic [31:0] done_new;

   assign b          = req_item.data_byte;
   assign cur_phase  = req_item.first_byte ? PH_HEADER : phase_ff;
   assign cur_pos    = req_item.first_byte ? 5'd0 : hdr_pos_ff;
   assign data_phase = compressed_ff ? PH_PACKET : PH_PIXEL;
   assign id_dec     = id_left_ff - 8'd1;
   assign run        = {1'b0, b[6:0]} + 8'd1;
   assign run_end    = {1'b0, done_cnt_ff} + 33'(run);
   assign asm_new    = assembly_ff | (24'(b) << {byte_idx_ff, 3'b000});
   assign n          = (compressed_ff && repeat_ff && pkt_left_ff != 8'd0) ? pkt_left_ff : 8'd1;
   assign done_new   = done_cnt_ff + 32'(n);

   always_comb begin
      phase_in      = phase_ff;
      hdr_pos_in    = hdr_pos_ff;
      id_left_in    = id_left_ff;
      compressed_in = compressed_ff;
      bpp_in        = bpp_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      total_in      = total_ff;
      done_cnt_in   = done_cnt_ff;
      repeat_in     = repeat_ff;
      pkt_left_in   = pkt_left_ff;
      assembly_in   = assembly_ff;
      byte_idx_in   = byte_idx_ff;
      evt           = '0;
      evt_push      = 1'b0;
      err           = 1'b0;
      err_code      = tgd_pkg::ERR_CMAP;
      complete      = 1'b0;

      if (accept) begin
         // restart drops whatever image was in flight
         if (req_item.first_byte) begin
            phase_in      = PH_HEADER;
            hdr_pos_in    = 5'd0;
            id_left_in    = 8'd0;
            compressed_in = 1'b0;
            bpp_in        = 3'd0;
            width_in      = 16'd0;
            height_in     = 16'd0;
            total_in      = 32'd0;
            done_cnt_in   = 32'd0;
            repeat_in     = 1'b0;
            pkt_left_in   = 8'd0;
            assembly_in   = 24'd0;
            byte_idx_in   = 2'd0;
         end

         unique case (cur_phase)
            PH_HEADER: begin
               unique case (cur_pos)
                  5'd0: id_left_in = b;
                  5'd1: begin
                     if (b != 8'd0) begin
                        err      = 1'b1;
                        err_code = tgd_pkg::ERR_CMAP;
                     end
                  end
                  5'd2: begin
                     if (b != 8'd2 && b != 8'd3 && b != 8'd10 && b != 8'd11) begin
                        err      = 1'b1;
                        err_code = tgd_pkg::ERR_TYPE;
                     end
                     compressed_in = (b == 8'd10 || b == 8'd11);
                  end
                  5'd12: width_in[7:0]   = b;
                  5'd13: width_in[15:8]  = b;
                  5'd14: height_in[7:0]  = b;
                  5'd15: height_in[15:8] = b;
                  5'd16: begin
                     if (width_ff == 16'd0 || height_ff == 16'd0 ||
                         (b != 8'd8 && b != 8'd24 && b != 8'd32)) begin
                        err      = 1'b1;
                        err_code = tgd_pkg::ERR_SIZE;
                     end else begin
                        bpp_in = b[5:3];
                     end
                  end
                  POS_LAST: begin
                     total_in = {16'd0, width_ff} * {16'd0, height_ff};
                     evt_push = 1'b1;
                     evt.kind = tgd_pkg::KIND_HEADER;
                     evt.data = {height_ff, width_ff};
                     evt.top  = b[5];
                     phase_in = (id_left_ff != 8'd0) ? PH_IDSKIP : data_phase;
                  end
                  default: ;
               endcase
               if (cur_pos < POS_LAST) begin
                  hdr_pos_in = cur_pos + 5'd1;
               end
            end
            PH_IDSKIP: begin
               id_left_in = id_dec;
               if (id_dec == 8'd0) begin
                  phase_in = data_phase;
               end
            end
            PH_PACKET: begin
               if (run_end > {1'b0, total_ff}) begin
                  err      = 1'b1;
                  err_code = tgd_pkg::ERR_OVERFLOW;
               end else begin
                  repeat_in   = b[7];
                  pkt_left_in = run;
                  phase_in    = PH_PIXEL;
               end
            end
            PH_PIXEL: begin
               if (bpp_ff == 3'd1) begin
                  evt.gray = 1'b1;
                  evt.data = {24'd0, b};
                  complete = 1'b1;
               end else if (byte_idx_ff != 2'd3) begin
                  assembly_in = asm_new;
                  if ({1'b0, byte_idx_ff} + 3'd1 >= bpp_ff) begin
                     evt.data = {8'hFF, asm_new};
                     complete = 1'b1;
                  end else begin
                     byte_idx_in = byte_idx_ff + 2'd1;
                  end
               end else begin
                  evt.data = {b, assembly_ff};
                  complete = 1'b1;
               end
               if (complete) begin
                  byte_idx_in = 2'd0;
                  assembly_in = 24'd0;
                  evt_push    = 1'b1;
                  evt.kind    = tgd_pkg::KIND_RUN;
                  evt.start   = done_cnt_ff;
                  evt.len     = n;
                  done_cnt_in = done_new;
                  if (compressed_ff) begin
                     pkt_left_in = (pkt_left_ff >= n) ? pkt_left_ff - n : 8'd0;
                  end
                  if (done_new >= total_ff) begin
                     evt.done = 1'b1;
                     phase_in = PH_IDLE;
                  end else if (compressed_ff && pkt_left_in == 8'd0) begin
                     phase_in = PH_PACKET;
                  end
               end
            end
            default: ;
         endcase

         // truncation only when no other error on this byte
         if (!err && req_item.last_byte && phase_in != PH_IDLE) begin
            err      = 1'b1;
            err_code = tgd_pkg::ERR_TRUNC;
         end
         if (err) begin
            phase_in = PH_IDLE;
            evt      = '0;
            evt.kind = tgd_pkg::KIND_ERROR;
            evt.code = err_code;
            evt.done = 1'b1;
            evt_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_pos_ff    <= 5'd0;
         id_left_ff    <= 8'd0;
         compressed_ff <= 1'b0;
         bpp_ff        <= 3'd0;
         width_ff      <= 16'd0;
         height_ff     <= 16'd0;
         total_ff      <= 32'd0;
         done_cnt_ff   <= 32'd0;
         repeat_ff     <= 1'b0;
         pkt_left_ff   <= 8'd0;
         assembly_ff   <= 24'd0;
         byte_idx_ff   <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         id_left_ff    <= id_left_in;
         compressed_ff <= compressed_in;
         bpp_ff        <= bpp_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         total_ff      <= total_in;
         done_cnt_ff   <= done_cnt_in;
         repeat_ff     <= repeat_in;
         pkt_left_ff   <= pkt_left_in;
         assembly_ff   <= assembly_in;
         byte_idx_ff   <= byte_idx_in;
      end
   end

   a_hdr_pos_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> hdr_pos_ff <= POS_LAST)
      else $error("header position past last header byte");

   a_pixel_needs_depth: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXEL |-> (bpp_ff == 3'd1 || bpp_ff == 3'd3 || bpp_ff == 3'd4))
      else $error("pixel phase without a valid pixel depth");

endmodule

`default_nettype wire

// File: rtl/tgd_queue.sv
// tgd_queue: short event FIFO between parser and formatter, flop based.
// Depends on tgd_pkg for the event type.
`default_nettype none

module tgd_queue #(
   parameter int unsigned Depth = tgd_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire tgd_pkg::evt_type wr_evt,
   input  wire logic             rd_en,
   output tgd_pkg::evt_type      rd_evt,
   output logic                  rd_valid,
   output logic                  full
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   tgd_pkg::evt_type  mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_wr, do_rd;

   assign full     = (count_ff == CntFull);
   assign rd_valid = (count_ff != '0);
   assign rd_evt   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_evt;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count above depth");

endmodule

`default_nettype wire

// File: rtl/tgd_formatter.sv
// tgd_formatter: back end; expands queued events into full result beats.
// Holds the result in an output register. Depends on tgd_pkg.
`default_nettype none

module tgd_formatter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tgd_pkg::evt_type head_evt,
   input  wire logic             head_valid,
   output logic                  head_pop,
   output tgd_pkg::rsp_type      rsp_item,
   output logic                  empty,
   input  wire logic             pop
);

   tgd_pkg::rsp_type rsp_ff, rsp_in;
   logic             valid_ff, valid_in;
   logic             is_run, is_hdr;

   assign is_run = (head_evt.kind == tgd_pkg::KIND_RUN);
   assign is_hdr = (head_evt.kind == tgd_pkg::KIND_HEADER);

   // take a new event when the output slot is free or being drained
   assign head_pop = head_valid && (!valid_ff || pop);

   always_comb begin
      rsp_in.kind         = head_evt.kind;
      rsp_in.pixel_bgra   = !is_run ? 32'd0 :
                            head_evt.gray ? {8'hFF, {3{head_evt.data[7:0]}}} : head_evt.data;
      rsp_in.start_index  = is_run ? head_evt.start : 32'd0;
      rsp_in.run_length   = is_run ? head_evt.len : 8'd0;
      rsp_in.image_width  = is_hdr ? head_evt.data[15:0] : 16'd0;
      rsp_in.image_height = is_hdr ? head_evt.data[31:16] : 16'd0;
      rsp_in.top_origin   = is_hdr ? head_evt.top : 1'b0;
      rsp_in.error_code   = head_evt.code;
      rsp_in.image_done   = head_evt.done;
      valid_in = head_pop ? 1'b1 : (pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;
   assign empty    = !valid_ff;

   a_error_ends_image: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ff.kind == tgd_pkg::KIND_ERROR) |->
         (rsp_ff.image_done && rsp_ff.pixel_bgra == 32'd0 && rsp_ff.run_length == 8'd0))
      else $error("error beat not marked done or carries pixel data");

endmodule

`default_nettype wire

// File: rtl/tga_image_stream_decoder_unit.sv
// tga_image_stream_decoder_unit: top level of the TGA byte-stream decoder.
// Instantiates tgd_parser, tgd_queue and tgd_formatter; depends on tgd_pkg.
//
//   channel   ports                     beat                    accepted when
//   input     req_item, push, full      one file byte + flags   push && !full
//   result    rsp_item, empty, pop      header / run / error    pop && !empty
//
// One byte per cycle sustained while full is low; a result passes through the
// event queue and then the output register before it is on rsp_item.
// The parser settles each byte in the accept cycle; the header multiply and the
// pixel-count add/compare are the longest paths there.
// full rises only when the event queue (QueueDepth entries) is full; the output
// register drains into the consumer independently, so stalls only back up.
// Synchronous active-high reset returns the parser to idle and empties both stages.
`default_nettype none

module tga_image_stream_decoder_unit #(
   parameter int unsigned QueueDepth = tgd_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tgd_pkg::req_type req_item,
   input  wire logic             push,
   output logic                  full,
   output tgd_pkg::rsp_type      rsp_item,
   output logic                  empty,
   input  wire logic             pop
);

   logic             accept;
   logic             evt_push;
   tgd_pkg::evt_type evt;
   tgd_pkg::evt_type head_evt;
   logic             head_valid;
   logic             head_pop;

   assign accept = push && !full;

   // front: byte classification and image state
   tgd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .evt_push (evt_push),
      .evt      (evt)
   );

   // decoupling queue; its full flag is the input backpressure
   tgd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (evt_push),
      .wr_evt   (evt),
      .rd_en    (head_pop),
      .rd_evt   (head_evt),
      .rd_valid (head_valid),
      .full     (full)
   );

   // back: result expansion and output register
   tgd_formatter u_formatter (
      .clock      (clock),
      .reset      (reset),
      .head_evt   (head_evt),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_item   (rsp_item),
      .empty      (empty),
      .pop        (pop)
   );

   a_result_follows_queue: assert property (@(posedge clock) disable iff (reset)
      (head_valid && empty) |=> !empty)
      else $error("queued event not moved into empty output slot");

endmodule

`default_nettype wire

// File: bench/tga_image_stream_decoder_unit_test.sv
// Self-checking bench for tga_image_stream_decoder_unit: TGA byte streams in,
// header/run/error beats out, checked against an in-bench decoder model.
// Depends on tgd_pkg and the decoder RTL only.
`default_nettype none

module tga_image_stream_decoder_unit_test;

   // TGA image types and depths the decoder accepts
   localparam logic [7:0] TYPE_TRUE     = 8'd2;
   localparam logic [7:0] TYPE_GREY     = 8'd3;
   localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
   localparam logic [7:0] TYPE_RLE_GREY = 8'd11;
   localparam logic [7:0] DEPTH_GREY    = 8'd8;
   localparam logic [7:0] DEPTH_TRUE    = 8'd24;
   localparam logic [7:0] DEPTH_ALPHA   = 8'd32;

   // Header byte offsets
   localparam int POS_ID_LEN    = 0;
   localparam int POS_CMAP_TYPE = 1;
   localparam int POS_IMG_TYPE  = 2;
   localparam int POS_WIDTH_LO  = 12;
   localparam int POS_WIDTH_HI  = 13;
   localparam int POS_HEIGHT_LO = 14;
   localparam int POS_HEIGHT_HI = 15;
   localparam int POS_DEPTH     = 16;
   localparam int POS_DESCR     = tgd_pkg::HDR_BYTES - 1;

   // Cycles with no beat on either side before the run is called hung
   localparam int QUIET_LIMIT = 2000;
   // Pixel data generated per file is capped; larger images end truncated
   localparam longint PIXEL_CAP = 130;

   // Model parse states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_ID_SKIP = 3'd2;
   localparam logic [2:0] ST_PACKET  = 3'd3;
   localparam logic [2:0] ST_PIXEL   = 3'd4;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   tgd_pkg::req_type req_item = '0;
   logic             push = 1'b0;
   logic             full;
   tgd_pkg::rsp_type rsp_item;
   logic             empty;
   logic             pop = 1'b0;

   tga_image_stream_decoder_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .push     (push),
      .full     (full),
      .rsp_item (rsp_item),
      .empty    (empty),
      .pop      (pop)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   tgd_pkg::req_type byte_feed[$];      // bytes waiting for the driver
   tgd_pkg::rsp_type due_results[$];    // decoder beats predicted but not yet seen
   logic    req_beat = 1'b0;   // input beat taken at the last rising edge
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles = 0;
   int      mismatches = 0;
   int      files_queued = 0;
   int      bytes_queued = 0;
   int      bytes_in = 0;
   int      results_out = 0;
   int      headers_seen = 0;
   int      runs_seen = 0;
   int      errors_seen = 0;

   // ------------------------------------------------------------------
   // Decoder model state
   // ------------------------------------------------------------------
   logic [2:0]   st_phase;
   logic [4:0]   hdr_pos;
   logic [7:0]   id_left;
   logic         compressed;
   logic [2:0]   pix_bytes;
   logic [15:0]  img_w;
   logic [15:0]  img_h;
   logic [31:0]  pix_total;
   logic [31:0]  pix_done;
   logic         rep_packet;
   logic [7:0]   pkt_left;
   logic [23:0]  pix_acc;
   logic [1:0]   byte_idx;

   task automatic clear_decoder();
      st_phase   = ST_IDLE;
      hdr_pos    = '0;
      id_left    = '0;
      compressed = 1'b0;
      pix_bytes  = '0;
      img_w      = '0;
      img_h      = '0;
      pix_total  = '0;
      pix_done   = '0;
      rep_packet = 1'b0;
      pkt_left   = '0;
      pix_acc    = '0;
      byte_idx   = '0;
   endtask

   // Advance the decoder model by one file byte and queue the beat it owes.
   task automatic decode_byte(input tgd_pkg::req_type r);
      logic [7:0]  b;
      logic        have;
      logic        err;
      logic        complete;
      logic [2:0]  err_code;
      logic [7:0]  run;
      logic [7:0]  n;
      logic [32:0] sum;
      logic [31:0] pix;
      tgd_pkg::rsp_type res;
      b        = r.data_byte;
      have     = 1'b0;
      err      = 1'b0;
      err_code = tgd_pkg::ERR_CMAP;
      pix      = '0;
      res      = '0;
      if (r.first_byte) begin
         clear_decoder();
         st_phase = ST_HEADER;
      end
      // bytes outside a file are dropped, last flag included
      if (st_phase != ST_IDLE) begin
         case (st_phase)
            ST_HEADER: begin
               case (int'(hdr_pos))
                  POS_ID_LEN: id_left = b;
                  POS_CMAP_TYPE: begin
                     if (b != 8'd0) begin
                        err = 1'b1;
                        err_code = tgd_pkg::ERR_CMAP;
                     end
                  end
                  POS_IMG_TYPE: begin
                     if (b != TYPE_TRUE && b != TYPE_GREY &&
                         b != TYPE_RLE_TRUE && b != TYPE_RLE_GREY) begin
                        err = 1'b1;
                        err_code = tgd_pkg::ERR_TYPE;
                     end
                     compressed = (b == TYPE_RLE_TRUE || b == TYPE_RLE_GREY);
                  end
                  POS_WIDTH_LO:  img_w[7:0]  = b;
                  POS_WIDTH_HI:  img_w[15:8] = b;
                  POS_HEIGHT_LO: img_h[7:0]  = b;
                  POS_HEIGHT_HI: img_h[15:8] = b;
                  POS_DEPTH: begin
                     if (img_w == 16'd0 || img_h == 16'd0 ||
                         (b != DEPTH_GREY && b != DEPTH_TRUE && b != DEPTH_ALPHA)) begin
                        err = 1'b1;
                        err_code = tgd_pkg::ERR_SIZE;
                     end else begin
                        pix_bytes = b[5:3];
                     end
                  end
                  POS_DESCR: begin
                     pix_total = {16'd0, img_w} * {16'd0, img_h};
                     have = 1'b1;
                     res.kind = tgd_pkg::KIND_HEADER;
                     res.image_width = img_w;
                     res.image_height = img_h;
                     res.top_origin = b[5];
                     if (id_left != 8'd0)
                        st_phase = ST_ID_SKIP;
                     else
                        st_phase = compressed ? ST_PACKET : ST_PIXEL;
                  end
                  default: ;
               endcase
               if (int'(hdr_pos) < POS_DESCR)
                  hdr_pos = hdr_pos + 5'd1;
            end
            ST_ID_SKIP: begin
               id_left = id_left - 8'd1;
               if (id_left == 8'd0)
                  st_phase = compressed ? ST_PACKET : ST_PIXEL;
            end
            ST_PACKET: begin
               run = {1'b0, b[6:0]} + 8'd1;
               sum = {1'b0, pix_done} + {25'd0, run};
               if (sum > {1'b0, pix_total}) begin
                  err = 1'b1;
                  err_code = tgd_pkg::ERR_OVERFLOW;
               end else begin
                  rep_packet = b[7];
                  pkt_left = run;
                  st_phase = ST_PIXEL;
               end
            end
            ST_PIXEL: begin
               complete = 1'b0;
               if (pix_bytes == 3'd1) begin
                  // grey fans out to B, G, R
                  pix = {8'hFF, b, b, b};
                  complete = 1'b1;
               end else if (byte_idx < 2'd3) begin
                  pix_acc = pix_acc | (24'(b) << (8 * byte_idx));
                  if (({1'b0, byte_idx} + 3'd1) >= pix_bytes) begin
                     pix = {8'hFF, pix_acc};
                     complete = 1'b1;
                  end else begin
                     byte_idx = byte_idx + 2'd1;
                  end
               end else begin
                  pix = {b, pix_acc};
                  complete = 1'b1;
               end
               if (complete) begin
                  n = 8'd1;
                  byte_idx = '0;
                  pix_acc = '0;
                  if (compressed && rep_packet && pkt_left != 8'd0)
                     n = pkt_left;
                  have = 1'b1;
                  res.kind = tgd_pkg::KIND_RUN;
                  res.pixel_bgra = pix;
                  res.start_index = pix_done;
                  res.run_length = n;
                  pix_done = pix_done + {24'd0, n};
                  if (compressed)
                     pkt_left = (pkt_left >= n) ? pkt_left - n : 8'd0;
                  if (pix_done >= pix_total) begin
                     res.image_done = 1'b1;
                     st_phase = ST_IDLE;
                  end else if (compressed && pkt_left == 8'd0) begin
                     st_phase = ST_PACKET;
                  end
               end
            end
            default: ;
         endcase
         // truncation replaces any header or run beat this byte owed
         if (!err && r.last_byte && st_phase != ST_IDLE) begin
            err = 1'b1;
            err_code = tgd_pkg::ERR_TRUNC;
         end
         if (err) begin
            st_phase = ST_IDLE;
            res = '0;
            res.kind = tgd_pkg::KIND_ERROR;
            res.error_code = err_code;
            res.image_done = 1'b1;
            have = 1'b1;
         end
         if (have)
            due_results.push_back(res);
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                   results_out, name, got, want));
   endtask

   task automatic check_result(input tgd_pkg::rsp_type got);
      tgd_pkg::rsp_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("beat %0d kind %0d arrived with nothing due",
                                   results_out, got.kind));
      end else begin
         want = due_results.pop_front();
         check_field("kind",         32'(got.kind),         32'(want.kind));
         check_field("pixel_bgra",   got.pixel_bgra,        want.pixel_bgra);
         check_field("start_index",  got.start_index,       want.start_index);
         check_field("run_length",   32'(got.run_length),   32'(want.run_length));
         check_field("image_width",  32'(got.image_width),  32'(want.image_width));
         check_field("image_height", 32'(got.image_height), 32'(want.image_height));
         check_field("top_origin",   32'(got.top_origin),   32'(want.top_origin));
         check_field("error_code",   32'(got.error_code),   32'(want.error_code));
         check_field("image_done",   32'(got.image_done),   32'(want.image_done));
         case (want.kind)
            tgd_pkg::KIND_HEADER: headers_seen++;
            tgd_pkg::KIND_RUN:    runs_seen++;
            default:              errors_seen++;
         endcase
      end
      results_out++;
   endtask

   // Monitor: takes both handshakes at the rising edge, feeds the model,
   // checks results and keeps the hang watchdog.
   always @(posedge clock) begin
      if (reset) begin
         req_beat <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_beat <= push && !full;
         if (push && !full) begin
            decode_byte(req_item);
            bytes_in++;
         end
         if (pop && !empty)
            check_result(rsp_item);
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("TIMEOUT: no beat for %0d cycles, %0d results still due",
                        QUIET_LIMIT, due_results.size());
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

   // Driver: a byte holds until taken; a fresh one may be withheld at random.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_beat) begin
         if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_item <= byte_feed.pop_front();
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Consumer: random back-pressure on the result side
   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic queue_noise(input int count, input bit allow_first);
      tgd_pkg::req_type item;
      repeat (count) begin
         item.data_byte = 8'($urandom);
         item.first_byte = allow_first && ($urandom_range(7) == 0);
         item.last_byte = 1'($urandom_range(1));
         byte_feed.push_back(item);
         bytes_queued++;
      end
   endtask

   // Build one TGA file and queue it. cut > 0 keeps only that many bytes;
   // overflow plants an RLE packet longer than the pixels left.
   task automatic queue_file(input logic [7:0] img_type, input logic [7:0] depth,
                             input logic [15:0] wd, input logic [15:0] ht,
                             input logic [7:0] id_len, input logic [7:0] cmap,
                             input int cut, input bit overflow,
                             input bit mark_last, input int trailing);
      logic [7:0] file_bytes[$];
      longint     left;
      int         bpp;
      int         run;
      int         count;
      bit         rle;
      bit         rep;
      tgd_pkg::req_type item;
      file_bytes.push_back(id_len);
      file_bytes.push_back(cmap);
      file_bytes.push_back(img_type);
      repeat (9) file_bytes.push_back(8'($urandom));   // map spec and origin
      file_bytes.push_back(wd[7:0]);
      file_bytes.push_back(wd[15:8]);
      file_bytes.push_back(ht[7:0]);
      file_bytes.push_back(ht[15:8]);
      file_bytes.push_back(depth);
      file_bytes.push_back(8'($urandom));               // descriptor
      repeat (id_len) file_bytes.push_back(8'($urandom));
      case (depth)
         DEPTH_TRUE:  bpp = 3;
         DEPTH_ALPHA: bpp = 4;
         default:     bpp = 1;
      endcase
      rle = (img_type == TYPE_RLE_TRUE || img_type == TYPE_RLE_GREY);
      left = longint'(wd) * longint'(ht);
      if (left > PIXEL_CAP)
         left = PIXEL_CAP;
      while (left > 0) begin
         if (!rle) begin
            repeat (bpp) file_bytes.push_back(8'($urandom));
            left--;
         end else if (overflow && (left <= 8 || $urandom_range(1) == 0)) begin
            run = $urandom_range(int'(left) + 1, 128);
            file_bytes.push_back({1'($urandom_range(1)), 7'(run - 1)});
            repeat (bpp) file_bytes.push_back(8'($urandom));
            left = 0;
         end else begin
            if (left >= 128) begin
               run = 128;
               rep = 1'b1;
            end else begin
               run = $urandom_range(1, int'(left));
               rep = 1'($urandom_range(1));
            end
            file_bytes.push_back({rep, 7'(run - 1)});
            if (rep)
               repeat (bpp) file_bytes.push_back(8'($urandom));
            else
               repeat (run * bpp) file_bytes.push_back(8'($urandom));
            left -= run;
         end
      end
      repeat (trailing) file_bytes.push_back(8'($urandom));
      count = file_bytes.size();
      if (cut > 0 && cut < count)
         count = cut;
      for (int i = 0; i < count; i++) begin
         item.data_byte = file_bytes[i];
         item.first_byte = (i == 0);
         item.last_byte = mark_last && (i == count - 1);
         byte_feed.push_back(item);
      end
      bytes_queued += count;
      files_queued++;
   endtask

   task automatic queue_random_file();
      int         roll;
      logic [7:0] ty;
      logic [7:0] dp;
      logic [15:0] wd;
      logic [15:0] ht;
      logic [7:0] idl;
      roll = $urandom_range(99);
      case ($urandom_range(3))
         0:       ty = TYPE_TRUE;
         1:       ty = TYPE_GREY;
         2:       ty = TYPE_RLE_TRUE;
         default: ty = TYPE_RLE_GREY;
      endcase
      case ($urandom_range(2))
         0:       dp = DEPTH_GREY;
         1:       dp = DEPTH_TRUE;
         default: dp = DEPTH_ALPHA;
      endcase
      wd = 16'($urandom_range(1, 6));
      ht = 16'($urandom_range(1, 4));
      idl = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
      if (roll < 60) begin
         queue_file(ty, dp, wd, ht, idl, 8'd0, 0, 1'b0, 1'b1,
                    ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (roll < 72) begin
         // cut short somewhere, last flag on the cut byte
         queue_file(ty, dp, wd, ht, idl, 8'd0,
                    $urandom_range(1, 18 + idl + 4 * wd * ht), 1'b0, 1'b1, 0);
      end else if (roll < 82) begin
         case ($urandom_range(4))
            0: queue_file(ty, dp, wd, ht, idl, 8'($urandom_range(1, 255)), 0,
                          1'b0, 1'b1, 0);
            // bit 4 set never names a supported type
            1: queue_file(8'($urandom) | 8'h10, dp, wd, ht, idl, 8'd0, 0, 1'b0, 1'b1, 0);
            2: queue_file(ty, dp, 16'd0, ht, idl, 8'd0, 0, 1'b0, 1'b1, 0);
            3: queue_file(ty, dp, wd, 16'd0, idl, 8'd0, 0, 1'b0, 1'b1, 0);
            // odd depths are never legal
            default: queue_file(ty, 8'($urandom) | 8'h01, wd, ht, idl, 8'd0, 0,
                                1'b0, 1'b1, 0);
         endcase
      end else if (roll < 88) begin
         queue_file($urandom_range(1) ? TYPE_RLE_TRUE : TYPE_RLE_GREY, dp, wd, ht,
                    idl, 8'd0, 0, 1'b1, 1'b1, 0);
      end else if (roll < 94) begin
         // abandoned mid-file, no last flag; the next first byte restarts
         queue_file(ty, dp, wd, ht, idl, 8'd0, $urandom_range(1, 30), 1'b0, 1'b0, 0);
      end else begin
         queue_noise($urandom_range(1, 5), 1'b1);
      end
   endtask

   task automatic wait_drained();
      while (byte_feed.size() != 0 || push || due_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int phase_start;
      clear_decoder();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every type and depth, each header check, overflow,
      // truncation, restart, stray bytes, and the largest header fields.
      queue_noise(3, 1'b0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd2, 16'd1, 8'd2, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_GREY,     DEPTH_GREY,  16'd1, 16'd1, 8'd0, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_RLE_TRUE, DEPTH_ALPHA, 16'd3, 16'd2, 8'd0, 8'd0,  0, 1'b0, 1'b1, 3);
      queue_file(TYPE_RLE_GREY, DEPTH_TRUE,  16'd2, 16'd2, 8'd1, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_ALPHA, 16'd1, 16'd1, 8'd3, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd1, 16'd1, 8'd0, 8'hFF, 0, 1'b0, 1'b1, 0);
      queue_file(8'd1,          DEPTH_TRUE,  16'd1, 16'd1, 8'd0, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd0, 16'd1, 8'd0, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd1, 16'd0, 8'd0, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     8'd16,       16'd1, 16'd1, 8'd0, 8'd0,  0, 1'b0, 1'b1, 0);
      queue_file(TYPE_RLE_TRUE, DEPTH_TRUE,  16'd2, 16'd2, 8'd0, 8'd0,  0, 1'b1, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd2, 16'd2, 8'd0, 8'd0, 20, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd2, 16'd2, 8'd0, 8'd0, 18, 1'b0, 1'b1, 0);
      queue_file(TYPE_TRUE,     DEPTH_TRUE,  16'd2, 16'd2, 8'd0, 8'd0, 22, 1'b0, 1'b0, 0);
      queue_file(TYPE_RLE_GREY, DEPTH_GREY,  16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 0,
                 1'b0, 1'b1, 0);
      wait_drained();

      // Random files under four idling mixes; each phase ends fully drained,
      // so the sender pauses at each phase end until the decoder has caught up.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < 20)
            queue_random_file();
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Coverage: %0d files, %0d input beats, %0d result beats", files_queued,
               bytes_in, results_out);
      $display("  (%0d headers, %0d pixel runs, %0d errors) across four idling mixes",
               headers_seen, runs_seen, errors_seen);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/tgd_pkg.sv
rtl/tgd_parser.sv
rtl/tgd_queue.sv
rtl/tgd_formatter.sv
rtl/tga_image_stream_decoder_unit.sv
bench/tga_image_stream_decoder_unit_test.sv
